>>> rtl/tmt64_pkg.sv
package tmt64_pkg;

    localparam int unsigned WORD_W    = 64;
    localparam int unsigned HALF_W    = 32;
    localparam int unsigned CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MASK_ONE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_TWO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMPER   = 2'd2;

    // command codes carried on the input tuser
    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    localparam logic [HALF_W-1:0] MASK_ONE_RST = 32'hfd581fab;
    localparam logic [HALF_W-1:0] MASK_TWO_RST = 32'h8c982326;
    localparam logic [WORD_W-1:0] TEMPER_RST   = 64'hbd7fc6ffefffffbc;
    localparam logic [WORD_W-1:0] LOW63        = 64'h7FFFFFFFFFFFFFFF;
    localparam logic [WORD_W-1:0] SEED_MULT    = 64'd6364136223846793005;
    localparam logic [WORD_W-1:0] LANE0_RST    = 64'd84;  // 'T'
    localparam logic [WORD_W-1:0] LANE1_RST    = 64'd77;  // 'M'
    localparam int unsigned       MIX_SHIFT    = 62;

    // partial product selects for the 64x64 low-half multiply
    localparam logic [1:0] MUL_LO_LO = 2'd0;
    localparam logic [1:0] MUL_HI_LO = 2'd1;
    localparam logic [1:0] MUL_LO_HI = 2'd2;

    typedef struct packed {
        logic       load;      // reseed accepted: build lanes from seed and masks
        logic       draw;      // draw accepted: advance and temper
        logic       mix;       // latch prev ^ (prev >> 62), preset accumulator
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       acc_full;  // acc += prod
        logic       acc_high;  // acc += prod << 32
        logic       upd;       // lane ^= acc + (prod << 32)
        logic       cert;      // period certification
    } t_dp_cmd;

endpackage

>>> rtl/tmt64_ctrl.sv
module tmt64_ctrl #(
    parameter int unsigned SEED_ROUNDS = 8,
    parameter int unsigned ROUND_W     = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_cmd,
    input  logic                  i_out_ready,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output tmt64_pkg::t_dp_cmd    o_cmd,
    output logic [ROUND_W-1:0]    o_round
);
    import tmt64_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MIX  = 3'd1;
    localparam logic [2:0] ST_MUL0 = 3'd2;
    localparam logic [2:0] ST_MUL1 = 3'd3;
    localparam logic [2:0] ST_MUL2 = 3'd4;
    localparam logic [2:0] ST_UPD  = 3'd5;
    localparam logic [2:0] ST_CERT = 3'd6;

    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(SEED_ROUNDS - 1);

    logic [2:0]         r_state, n_state;
    logic [ROUND_W-1:0] r_round, n_round;
    logic               r_out_valid, n_out_valid;
    logic               w_accept;

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_round     = r_round;

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_in_cmd == CMD_RESEED)) begin
                    o_cmd.load = 1'b1;
                    n_round    = ROUND_W'(1);
                    n_state    = ST_MIX;
                end
                o_cmd.draw = w_accept && (i_in_cmd == CMD_DRAW);
            end
            ST_MIX: begin
                o_cmd.mix = 1'b1;
                n_state   = ST_MUL0;
            end
            ST_MUL0: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_LO_LO;
                n_state       = ST_MUL1;
            end
            ST_MUL1: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MUL_HI_LO;
                o_cmd.acc_full = 1'b1;
                n_state        = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MUL_LO_HI;
                o_cmd.acc_high = 1'b1;
                n_state        = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                if (r_round == LAST_ROUND) begin
                    n_state = ST_CERT;
                end else begin
                    n_round = r_round + ROUND_W'(1);
                    n_state = ST_MIX;
                end
            end
            ST_CERT: begin
                o_cmd.cert = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.draw) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTH
    a_reseed_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_cmd == CMD_RESEED)) |=> (r_state == ST_MIX && r_round == 1))
        else $error("reseed did not start the seed rounds");

    a_draw_gives_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_cmd == CMD_DRAW)) |=> r_out_valid)
        else $error("draw did not present an item");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_round >= 1 && r_round <= LAST_ROUND))
        else $error("seed round counter out of range");

    a_cert_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CERT) |=> (r_state == ST_IDLE))
        else $error("certification did not end the reseed");
`endif

endmodule

>>> rtl/tmt64_datapath.sv
module tmt64_datapath #(
    parameter int unsigned ROUND_W = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tmt64_pkg::t_dp_cmd            i_cmd,
    input  logic [ROUND_W-1:0]            i_round,
    input  logic [tmt64_pkg::WORD_W-1:0]  i_seed,
    input  logic                          i_cfg_we,
    input  logic [tmt64_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tmt64_pkg::WORD_W-1:0]  i_cfg_data,
    output logic [tmt64_pkg::WORD_W-1:0]  o_random
);
    import tmt64_pkg::*;

    logic [WORD_W-1:0] r_lane0, r_lane1, n_lane0, n_lane1;
    logic [HALF_W-1:0] r_mask_one, r_mask_two;
    logic [WORD_W-1:0] r_temper;
    logic [WORD_W-1:0] r_mix, r_prod, r_acc, r_out;

    logic [WORD_W-1:0] w_x0, w_x1, w_x2, w_x3, w_x4;
    logic [WORD_W-1:0] w_adv0, w_adv1, w_t0, w_t1;
    logic [WORD_W-1:0] w_prev, w_sum;
    logic [HALF_W-1:0] w_ma, w_mb;
    logic [WORD_W-1:0] w_prod;

    // draw: state transition, then tempering of the new lanes
    always_comb begin
        w_x0   = (r_lane0 & LOW63) ^ r_lane1;
        w_x1   = w_x0 ^ (w_x0 << 12);
        w_x2   = w_x1 ^ (w_x1 >> 32);
        w_x3   = w_x2 ^ (w_x2 << 32);
        w_x4   = w_x3 ^ (w_x3 << 11);
        w_adv0 = r_lane1 ^ (w_x4[0] ? {{HALF_W{1'b0}}, r_mask_one} : '0);
        w_adv1 = w_x4 ^ (w_x4[0] ? {r_mask_two, {HALF_W{1'b0}}} : '0);
        w_t0   = (w_adv0 + w_adv1) ^ (w_adv0 >> 8);
        w_t1   = w_t0 ^ (w_t0[0] ? r_temper : '0);
    end

    // seed rounds: round r reads the lane written by round r-1
    assign w_prev = i_round[0] ? r_lane0 : r_lane1;
    assign w_sum  = r_acc + {r_prod[HALF_W-1:0], {HALF_W{1'b0}}};

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_LO_LO: begin
                w_ma = r_mix[HALF_W-1:0];
                w_mb = SEED_MULT[HALF_W-1:0];
            end
            MUL_HI_LO: begin
                w_ma = r_mix[WORD_W-1:HALF_W];
                w_mb = SEED_MULT[HALF_W-1:0];
            end
            default: begin
                w_ma = r_mix[HALF_W-1:0];
                w_mb = SEED_MULT[WORD_W-1:HALF_W];
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    always_comb begin
        n_lane0 = r_lane0;
        n_lane1 = r_lane1;
        if (i_cmd.load) begin
            n_lane0 = i_seed ^ {r_mask_one, {HALF_W{1'b0}}};
            n_lane1 = {{HALF_W{1'b0}}, r_mask_two} ^ r_temper;
        end else if (i_cmd.draw) begin
            n_lane0 = w_adv0;
            n_lane1 = w_adv1;
        end else if (i_cmd.upd) begin
            if (i_round[0]) begin
                n_lane1 = r_lane1 ^ w_sum;
            end else begin
                n_lane0 = r_lane0 ^ w_sum;
            end
        end else if (i_cmd.cert) begin
            if (((r_lane0 & LOW63) == '0) && (r_lane1 == '0)) begin
                n_lane0 = LANE0_RST;
                n_lane1 = LANE1_RST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane0    <= LANE0_RST;
            r_lane1    <= LANE1_RST;
            r_mask_one <= MASK_ONE_RST;
            r_mask_two <= MASK_TWO_RST;
            r_temper   <= TEMPER_RST;
        end else begin
            r_lane0 <= n_lane0;
            r_lane1 <= n_lane1;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MASK_ONE: r_mask_one <= i_cfg_data[HALF_W-1:0];
                    REG_MASK_TWO: r_mask_two <= i_cfg_data[HALF_W-1:0];
                    REG_TEMPER:   r_temper   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mix) begin
            r_mix <= w_prev ^ (w_prev >> MIX_SHIFT);
            r_acc <= WORD_W'(i_round);
        end else if (i_cmd.acc_full) begin
            r_acc <= r_acc + r_prod;
        end else if (i_cmd.acc_high) begin
            r_acc <= w_sum;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_cmd.draw) begin
            r_out <= w_t1;
        end
    end

    assign o_random = r_out;

endmodule

>>> rtl/tinymt64_random_generator_top.sv
// TinyMT64 pseudo-random generator. An input item with tuser low is a draw: it
// advances the 127-bit state and presents one tempered 64-bit item on the master
// side; a draw is taken every cycle while no reseed runs and the output register
// is free or being emptied. An item with tuser high reseeds from tdata, produces
// nothing and holds the input off while the seed rounds and the certification
// run, each round doing its 64-bit multiply as three 32x32 partial products via
// a single shared multiplier. The user must write the masks through the config
// port only while idle, not enforced by the block; they apply from the next item.
module tinymt64_random_generator_top #(
    parameter int unsigned SEED_ROUNDS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [tmt64_pkg::WORD_W-1:0]    s_axis_tdata,   // [63:0] seed_value
    input  logic                            s_axis_tuser,   // [0] cmd
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [tmt64_pkg::WORD_W-1:0]    m_axis_tdata,   // [63:0] random_value
    input  logic                            i_cfg_we,
    input  logic [tmt64_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tmt64_pkg::WORD_W-1:0]    i_cfg_data
);
    import tmt64_pkg::*;

    localparam int unsigned ROUND_W = $clog2(SEED_ROUNDS);

    t_dp_cmd            w_cmd;
    logic [ROUND_W-1:0] w_round;

    tmt64_ctrl #(
        .SEED_ROUNDS (SEED_ROUNDS),
        .ROUND_W     (ROUND_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_cmd    (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd),
        .o_round     (w_round)
    );

    tmt64_datapath #(
        .ROUND_W (ROUND_W)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_round    (w_round),
        .i_seed     (s_axis_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_random   (m_axis_tdata)
    );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tmt64_pkg::*;

    localparam int unsigned ROUNDS = 8;
    // index 3 has no register behind it; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    // reseed busy time plus margin, used before any mask write and at the end
    localparam int SETTLE_CYCLES = 5 * (ROUNDS - 1) + 2 + 16;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 92;
    localparam int N_DIRECTED    = 16;

    typedef struct packed {
        logic        cmd;
        logic [63:0] seed;
    } t_stim;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = CMD_DRAW;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_idx     = '0;
    logic [63:0] i_cfg_data    = '0;

    // predictor state: two generator lanes and the three matrix registers
    logic [63:0] gen_a;
    logic [63:0] gen_b;
    logic [31:0] tmask_a;
    logic [31:0] tmask_b;
    logic [63:0] out_mask;

    logic [63:0] pending_draws[$];
    int          mismatches = 0;
    bit          quiet      = 1'b0;

    t_stim directed_rows [N_DIRECTED] = '{
        '{CMD_DRAW,   64'h0000_0000_0000_0000},
        '{CMD_DRAW,   64'hFFFF_FFFF_FFFF_FFFF},  // seed bits ignored on a draw
        '{CMD_DRAW,   64'h0123_4567_89AB_CDEF},
        '{CMD_RESEED, 64'h0000_0000_0000_0000},
        '{CMD_DRAW,   64'h0000_0000_0000_0000},
        '{CMD_DRAW,   64'h0000_0000_0000_0000},
        '{CMD_RESEED, 64'hFFFF_FFFF_FFFF_FFFF},
        '{CMD_DRAW,   64'h0000_0000_0000_0000},
        '{CMD_RESEED, 64'h8000_0000_0000_0000},
        '{CMD_DRAW,   64'h0000_0000_0000_0000},
        '{CMD_RESEED, 64'h0000_0000_0000_0001},
        '{CMD_RESEED, 64'h5555_5555_5555_5555},  // back-to-back reseeds
        '{CMD_DRAW,   64'h0000_0000_0000_0000},
        '{CMD_RESEED, 64'hAAAA_AAAA_AAAA_AAAA},
        '{CMD_DRAW,   64'hFFFF_FFFF_FFFF_FFFF},
        '{CMD_DRAW,   64'h0000_0000_0000_0000}
    };

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    tinymt64_random_generator_top #(
        .SEED_ROUNDS(ROUNDS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    function automatic logic [63:0] seed_mix(input logic [63:0] p);
        return p ^ (p >> MIX_SHIFT);
    endfunction

    task automatic reseed_lanes(input logic [63:0] seed);
        logic [63:0] w [2];
        w[0] = seed ^ {tmask_a, 32'h0};
        w[1] = {32'h0, tmask_b} ^ out_mask;
        for (int r = 1; r < ROUNDS; r++) begin
            w[r % 2] ^= 64'(r) + SEED_MULT * seed_mix(w[(r - 1) % 2]);
        end
        gen_a = w[0];
        gen_b = w[1];
        // period certification: bit 63 of lane a does not count
        if ((gen_a & LOW63) == 64'h0 && gen_b == 64'h0) begin
            gen_a = LANE0_RST;
            gen_b = LANE1_RST;
        end
    endtask

    // runs the seed rounds backward: which starting lanes end in t0/t1
    task automatic unwind_rounds(input logic [63:0] t0, input logic [63:0] t1,
                                 output logic [63:0] s0, output logic [63:0] s1);
        logic [63:0] w [2];
        w[0] = t0;
        w[1] = t1;
        for (int r = ROUNDS - 1; r >= 1; r--) begin
            w[r % 2] ^= 64'(r) + SEED_MULT * seed_mix(w[(r + 1) % 2]);
        end
        s0 = w[0];
        s1 = w[1];
    endtask

    task automatic draw_value(output logic [63:0] value);
        logic [63:0] x;
        x = (gen_a & LOW63) ^ gen_b;
        x ^= x << 12;
        x ^= x >> 32;
        x ^= x << 32;
        x ^= x << 11;
        if (x[0]) begin
            gen_a = gen_b ^ {32'h0, tmask_a};
            gen_b = x ^ {tmask_b, 32'h0};
        end else begin
            gen_a = gen_b;
            gen_b = x;
        end
        value = gen_a + gen_b;
        value ^= gen_a >> 8;
        if (value[0]) begin
            value ^= out_mask;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch %s: got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic send_item(input logic cmd, input logic [63:0] seed);
        logic [63:0] value;
        while (!quiet && $urandom_range(99) < 30) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= seed;
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (cmd == CMD_RESEED) begin
            reseed_lanes(seed);
        end else begin
            draw_value(value);
            pending_draws.push_back(value);
        end
    endtask

    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_MASK_ONE: tmask_a  = data[31:0];
            REG_MASK_TWO: tmask_b  = data[31:0];
            REG_TEMPER:   out_mask = data;
            default: ;
        endcase
    endtask

    // upper halves of the 32-bit registers carry garbage that must be dropped
    task automatic load_masks(input logic [63:0] a, input logic [63:0] b,
                              input logic [63:0] t);
        cfg_write(REG_UNUSED, {$urandom, $urandom});
        cfg_write(REG_MASK_ONE, a);
        cfg_write(REG_MASK_TWO, b);
        cfg_write(REG_TEMPER, t);
        i_cfg_we <= 1'b0;
    endtask

    // pick masks and seed so the seed rounds land on t0/t1, then draw twice
    task automatic certify_case(input logic [63:0] t0, input logic [63:0] t1);
        logic [63:0] s0;
        logic [63:0] s1;
        settle_idle();
        unwind_rounds(t0, t1, s0, s1);
        load_masks({$urandom, tmask_a}, {32'h0, tmask_b}, s1 ^ {32'h0, tmask_b});
        send_item(CMD_RESEED, s0 ^ {tmask_a, 32'h0});
        send_item(CMD_DRAW, {$urandom, $urandom});
        send_item(CMD_DRAW, 64'h0);
    endtask

    function automatic logic [63:0] pick_seed();
        case ($urandom_range(7))
            0: return 64'h0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    always @(posedge i_clk) begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 30);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_draws.size() == 0) begin
                report_mismatch("item with no draw pending", m_axis_tdata, '0);
            end else begin
                if (m_axis_tdata !== pending_draws[0]) begin
                    report_mismatch("random_value", m_axis_tdata, pending_draws[0]);
                end
                void'(pending_draws.pop_front());
            end
        end
    end

    initial begin
        logic [63:0] seed;
        logic        cmd;
        gen_a    = LANE0_RST;
        gen_b    = LANE1_RST;
        tmask_a  = MASK_ONE_RST;
        tmask_b  = MASK_TWO_RST;
        out_mask = TEMPER_RST;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            send_item(directed_rows[k].cmd, directed_rows[k].seed);
        end

        // all-zero state, zero with only bit 63 set, and two near misses
        certify_case(64'h0, 64'h0);
        certify_case(64'h8000_0000_0000_0000, 64'h0);
        certify_case(64'h0, 64'h1);
        certify_case(64'h1, 64'h0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle_idle();
            case (p)
                0: load_masks({32'h0, MASK_ONE_RST}, {32'h0, MASK_TWO_RST}, TEMPER_RST);
                1: load_masks(64'h0, 64'h0, 64'h0);
                2: load_masks('1, '1, '1);
                default: load_masks({$urandom, $urandom}, {$urandom, $urandom},
                                    {$urandom, $urandom});
            endcase
            quiet = (p == 3);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                cmd  = ($urandom_range(99) < 10) ? CMD_RESEED : CMD_DRAW;
                seed = pick_seed();
                send_item(cmd, seed);
            end
            quiet = 1'b0;
        end

        settle_idle();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
